>>> hdl/sid_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the segment intersection block
// no dependencies
package sid_pkg;

	// orientation of a point against a directed segment
	typedef enum logic [1:0] {
		ORI_ZERO = 2'b00,
		ORI_POS  = 2'b01,
		ORI_NEG  = 2'b10
	} ori_t;

	// per-item status carried alongside the arithmetic
	typedef struct packed {
		logic hit;
		logic par;
	} sid_flags_t;

	// depth of the queue between front and back
	localparam int unsigned SID_QDEPTH = 4;
	localparam int unsigned SID_QPTR_W = 2;
	localparam int unsigned SID_QCNT_W = 3;

endpackage

>>> hdl/sid_front.sv
`timescale 1ns / 1ps
// front part: orientation test, determinant and cramer numerators
// depends on sid_pkg
module sid_front import sid_pkg::*; #(
	parameter int CB = 13
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    en,
	input  logic                    in_vld,
	input  logic signed [CB-1:0]    ax0,
	input  logic signed [CB-1:0]    ay0,
	input  logic signed [CB-1:0]    ax1,
	input  logic signed [CB-1:0]    ay1,
	input  logic signed [CB-1:0]    bx0,
	input  logic signed [CB-1:0]    by0,
	input  logic signed [CB-1:0]    bx1,
	input  logic signed [CB-1:0]    by1,
	output logic                    out_vld,
	output sid_flags_t              flags,
	output logic signed [2*CB+2:0]  det,
	output logic signed [3*CB+2:0]  numx,
	output logic signed [3*CB+2:0]  numy
);

	localparam int DFW = CB + 1;
	localparam int PW  = 2 * CB + 2;
	localparam int DW  = 2 * CB + 3;
	localparam int CW  = 2 * CB + 1;
	localparam int NW  = 3 * CB + 3;

	function automatic logic in_range(input logic signed [CB-1:0] p,
		input logic signed [CB-1:0] r, input logic signed [CB-1:0] q);
		in_range = (q >= p || q >= r) && (q <= p || q <= r);
	endfunction

	function automatic ori_t ori_of(input logic signed [DW-1:0] v);
		ori_t o;
		if (v == '0) begin
			o = ORI_ZERO;
		end else if (v[DW-1]) begin
			o = ORI_NEG;
		end else begin
			o = ORI_POS;
		end
		ori_of = o;
	endfunction

	// stage 1: differences and bounding box tests
	logic                  vld_s1;
	logic signed [DFW-1:0] va_s1, ua_s1, vb_s1, ub_s1;
	logic signed [DFW-1:0] e1x_s1, e1y_s1, e2x_s1, e2y_s1;
	logic signed [DFW-1:0] e3x_s1, e3y_s1, e4x_s1, e4y_s1;
	logic signed [CB-1:0]  ax0_s1, ay0_s1, ax1_s1, ay1_s1;
	logic signed [CB-1:0]  bx0_s1, by0_s1, bx1_s1, by1_s1;
	logic [3:0]            win_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			va_s1  <= DFW'(ax1) - DFW'(ax0);
			ua_s1  <= DFW'(ay1) - DFW'(ay0);
			vb_s1  <= DFW'(bx1) - DFW'(bx0);
			ub_s1  <= DFW'(by1) - DFW'(by0);
			e1x_s1 <= DFW'(bx0) - DFW'(ax1);
			e1y_s1 <= DFW'(by0) - DFW'(ay1);
			e2x_s1 <= DFW'(bx1) - DFW'(ax1);
			e2y_s1 <= DFW'(by1) - DFW'(ay1);
			e3x_s1 <= DFW'(ax0) - DFW'(bx1);
			e3y_s1 <= DFW'(ay0) - DFW'(by1);
			e4x_s1 <= DFW'(ax1) - DFW'(bx1);
			e4y_s1 <= DFW'(ay1) - DFW'(by1);
			ax0_s1 <= ax0;
			ay0_s1 <= ay0;
			ax1_s1 <= ax1;
			ay1_s1 <= ay1;
			bx0_s1 <= bx0;
			by0_s1 <= by0;
			bx1_s1 <= bx1;
			by1_s1 <= by1;
			win_s1[0] <= in_range(ax0, ax1, bx0) && in_range(ay0, ay1, by0);
			win_s1[1] <= in_range(ax0, ax1, bx1) && in_range(ay0, ay1, by1);
			win_s1[2] <= in_range(bx0, bx1, ax0) && in_range(by0, by1, ay0);
			win_s1[3] <= in_range(bx0, bx1, ax1) && in_range(by0, by1, ay1);
		end
	end

	// stage 2: all first-level products
	logic                 vld_s2;
	logic signed [PW-1:0] o1a_s2, o1b_s2, o2a_s2, o2b_s2;
	logic signed [PW-1:0] o3a_s2, o3b_s2, o4a_s2, o4b_s2;
	logic signed [PW-1:0] da_s2, db_s2;
	logic signed [PW-1:0] caa_s2, cab_s2, cba_s2, cbb_s2;
	logic signed [DFW-1:0] va_s2, ua_s2, vb_s2, ub_s2;
	logic [3:0]           win_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o1a_s2 <= PW'(ua_s1) * PW'(e1x_s1);
			o1b_s2 <= PW'(va_s1) * PW'(e1y_s1);
			o2a_s2 <= PW'(ua_s1) * PW'(e2x_s1);
			o2b_s2 <= PW'(va_s1) * PW'(e2y_s1);
			o3a_s2 <= PW'(ub_s1) * PW'(e3x_s1);
			o3b_s2 <= PW'(vb_s1) * PW'(e3y_s1);
			o4a_s2 <= PW'(ub_s1) * PW'(e4x_s1);
			o4b_s2 <= PW'(vb_s1) * PW'(e4y_s1);
			da_s2  <= PW'(va_s1) * PW'(ub_s1);
			db_s2  <= PW'(ua_s1) * PW'(vb_s1);
			caa_s2 <= PW'(ax0_s1) * PW'(ay1_s1);
			cab_s2 <= PW'(ay0_s1) * PW'(ax1_s1);
			cba_s2 <= PW'(bx0_s1) * PW'(by1_s1);
			cbb_s2 <= PW'(by0_s1) * PW'(bx1_s1);
			va_s2  <= va_s1;
			ua_s2  <= ua_s1;
			vb_s2  <= vb_s1;
			ub_s2  <= ub_s1;
			win_s2 <= win_s1;
		end
	end

	// stage 3: orientations, determinant, line constants
	logic                 vld_s3;
	ori_t                 o1_s3, o2_s3, o3_s3, o4_s3;
	logic signed [DW-1:0] det_s3;
	logic signed [CW-1:0] ca_s3, cb_s3;
	logic signed [DFW-1:0] va_s3, ua_s3, vb_s3, ub_s3;
	logic [3:0]           win_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			o1_s3  <= ori_of(DW'(o1a_s2) - DW'(o1b_s2));
			o2_s3  <= ori_of(DW'(o2a_s2) - DW'(o2b_s2));
			o3_s3  <= ori_of(DW'(o3a_s2) - DW'(o3b_s2));
			o4_s3  <= ori_of(DW'(o4a_s2) - DW'(o4b_s2));
			det_s3 <= DW'(da_s2) - DW'(db_s2);
			ca_s3  <= CW'(caa_s2) - CW'(cab_s2);
			cb_s3  <= CW'(cba_s2) - CW'(cbb_s2);
			va_s3  <= va_s2;
			ua_s3  <= ua_s2;
			vb_s3  <= vb_s2;
			ub_s3  <= ub_s2;
			win_s3 <= win_s2;
		end
	end

	// stage 4: hit decision and split numerator products
	logic                  vld_s4;
	sid_flags_t            fl_s4;
	logic signed [DW-1:0]  det_s4;
	logic signed [PW-1:0]  xh1_s4, xh2_s4, xl1_s4, xl2_s4;
	logic signed [PW-1:0]  yh1_s4, yh2_s4, yl1_s4, yl2_s4;
	logic signed [DFW-1:0] cah, cal, cbh, cbl;
	logic                  hit;

	assign cah = ca_s3[CW-1:CB];
	assign cbh = cb_s3[CW-1:CB];
	assign cal = {1'b0, ca_s3[CB-1:0]};
	assign cbl = {1'b0, cb_s3[CB-1:0]};

	assign hit = (o1_s3 != o2_s3 && o3_s3 != o4_s3)
		|| (o1_s3 == ORI_ZERO && win_s3[0])
		|| (o2_s3 == ORI_ZERO && win_s3[1])
		|| (o3_s3 == ORI_ZERO && win_s3[2])
		|| (o4_s3 == ORI_ZERO && win_s3[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fl_s4.hit <= hit;
			fl_s4.par <= (det_s3 == '0);
			det_s4    <= det_s3;
			xh1_s4    <= PW'(va_s3) * PW'(cbh);
			xh2_s4    <= PW'(vb_s3) * PW'(cah);
			xl1_s4    <= PW'(va_s3) * PW'(cbl);
			xl2_s4    <= PW'(vb_s3) * PW'(cal);
			yh1_s4    <= PW'(ua_s3) * PW'(cbh);
			yh2_s4    <= PW'(ub_s3) * PW'(cah);
			yl1_s4    <= PW'(ua_s3) * PW'(cbl);
			yl2_s4    <= PW'(ub_s3) * PW'(cal);
		end
	end

	// stage 5: assemble numerators
	logic                 vld_s5;
	sid_flags_t           fl_s5;
	logic signed [DW-1:0] det_s5;
	logic signed [NW-1:0] nx_s5, ny_s5;
	logic signed [NW-1:0] nxh, nyh;

	assign nxh = NW'(xh1_s4) - NW'(xh2_s4);
	assign nyh = NW'(yh1_s4) - NW'(yh2_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fl_s5  <= fl_s4;
			det_s5 <= det_s4;
			nx_s5  <= (nxh <<< CB) + NW'(xl1_s4) - NW'(xl2_s4);
			ny_s5  <= (nyh <<< CB) + NW'(yl1_s4) - NW'(yl2_s4);
		end
	end

	assign out_vld = vld_s5;
	assign flags   = fl_s5;
	assign det     = det_s5;
	assign numx    = nx_s5;
	assign numy    = ny_s5;

endmodule

>>> hdl/sid_queue.sv
`timescale 1ns / 1ps
// short item queue between the front and back parts
// depends on sid_pkg
module sid_queue import sid_pkg::*; #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  logic [W-1:0] din,
	output logic         full,
	input  logic         pop,
	output logic         empty,
	output logic [W-1:0] dout
);

	logic [W-1:0]            mem_q [0:SID_QDEPTH-1];
	logic [SID_QPTR_W-1:0]   wr_q, rd_q;
	logic [SID_QCNT_W-1:0]   cnt_q;

	assign full  = (cnt_q == SID_QCNT_W'(SID_QDEPTH));
	assign empty = (cnt_q == '0);
	assign dout  = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

>>> hdl/sid_div.sv
`timescale 1ns / 1ps
// pipelined rounding divider, one quotient bit per stage, saturating result
// depends on sid_pkg
module sid_div import sid_pkg::*; #(
	parameter int CB = 13
) (
	input  logic                   clk,
	input  logic                   en,
	input  logic signed [3*CB+2:0] num,
	input  logic signed [2*CB+2:0] den,
	output logic signed [CB-1:0]   res
);

	localparam int NW = 3 * CB + 3;
	localparam int DW = 2 * CB + 3;
	localparam int Q  = CB + 1;
	localparam int OW = DW + Q;

	// stage 1: sign and magnitudes
	logic          neg_s1;
	logic [NW-1:0] n_s1;
	logic [DW-1:0] d_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			neg_s1 <= num[NW-1] ^ den[DW-1];
			n_s1   <= num[NW-1] ? NW'(-num) : NW'(num);
			d_s1   <= den[DW-1] ? DW'(-den) : DW'(den);
		end
	end

	// stage 2 and division steps share these arrays, index 0 is stage 2
	logic [DW-1:0] r_q   [0:Q];
	logic [Q-1:0]  qt_q  [0:Q];
	logic [Q-1:0]  nl_q  [0:Q];
	logic [DW-1:0] d_q   [0:Q];
	logic          neg_q [0:Q];
	logic          ovf_q [0:Q];

	// overflow check and initial partial remainder
	always_ff @(posedge clk) begin
		if (en) begin
			ovf_q[0] <= OW'(n_s1) >= {d_s1, Q'(0)};
			r_q[0]   <= DW'(n_s1[NW-1:Q]);
			qt_q[0]  <= '0;
			nl_q[0]  <= n_s1[Q-1:0];
			d_q[0]   <= d_s1;
			neg_q[0] <= neg_s1;
		end
	end

	// restoring division, one bit per stage
	for (genvar k = 1; k <= Q; k++) begin : g_step
		logic [DW:0] t;
		logic [DW:0] diff;
		logic        ge;

		assign t    = {r_q[k-1], nl_q[k-1][Q-k]};
		assign diff = t - {1'b0, d_q[k-1]};
		assign ge   = (t >= {1'b0, d_q[k-1]});

		always_ff @(posedge clk) begin
			if (en) begin
				r_q[k]   <= ge ? diff[DW-1:0] : t[DW-1:0];
				qt_q[k]  <= {qt_q[k-1][Q-2:0], ge};
				nl_q[k]  <= nl_q[k-1];
				d_q[k]   <= d_q[k-1];
				neg_q[k] <= neg_q[k-1];
				ovf_q[k] <= ovf_q[k-1];
			end
		end
	end

	// round to nearest, ties to even
	logic [Q:0] qr_q;
	logic       negr_q, ovfr_q;
	logic       up;

	assign up = ({r_q[Q], 1'b0} > {1'b0, d_q[Q]})
		|| (({r_q[Q], 1'b0} == {1'b0, d_q[Q]}) && qt_q[Q][0]);

	always_ff @(posedge clk) begin
		if (en) begin
			qr_q   <= {1'b0, qt_q[Q]} + (Q+1)'(up);
			negr_q <= neg_q[Q];
			ovfr_q <= ovf_q[Q];
		end
	end

	// saturate and apply sign
	logic [Q:0] lim;
	logic [Q:0] mag;
	logic [Q:0] sgn;
	logic signed [CB-1:0] res_q;

	assign lim = negr_q ? ((Q+1)'(1) << (CB - 1)) : (((Q+1)'(1) << (CB - 1)) - 1'b1);
	assign mag = (ovfr_q || qr_q > lim) ? lim : qr_q;
	assign sgn = negr_q ? -mag : mag;

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= sgn[CB-1:0];
		end
	end

	assign res = res_q;

endmodule

>>> hdl/sid_back.sv
`timescale 1ns / 1ps
// back part: divides both numerators and drives the result register
// depends on sid_pkg and sid_div
module sid_back import sid_pkg::*; #(
	parameter int CB = 13
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   q_empty,
	output logic                   q_pop,
	input  sid_flags_t             q_flags,
	input  logic signed [2*CB+2:0] q_det,
	input  logic signed [3*CB+2:0] q_numx,
	input  logic signed [3*CB+2:0] q_numy,
	output logic                   out_vld,
	input  logic                   out_stall,
	output sid_flags_t             out_flags,
	output logic signed [CB-1:0]   out_x,
	output logic signed [CB-1:0]   out_y
);

	localparam int LAT = CB + 5;

	logic       en;
	logic       vld_q [1:LAT];
	sid_flags_t fl_q  [1:LAT];
	logic signed [CB-1:0] dx, dy;

	// whole pipeline holds while the result register is loaded and stalled
	assign en    = !(vld_q[LAT] && out_stall);
	assign q_pop = en && !q_empty;

	// valid and flags ride alongside the dividers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 1; i <= LAT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_q[1] <= !q_empty;
			for (int i = 2; i <= LAT; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fl_q[1] <= q_flags;
			for (int i = 2; i <= LAT; i++) begin
				fl_q[i] <= fl_q[i-1];
			end
		end
	end

	sid_div #(.CB(CB)) u_div_x (
		.clk (clk),
		.en  (en),
		.num (q_numx),
		.den (q_det),
		.res (dx)
	);

	sid_div #(.CB(CB)) u_div_y (
		.clk (clk),
		.en  (en),
		.num (q_numy),
		.den (q_det),
		.res (dy)
	);

	// point forced to zero for parallel lines
	assign out_vld   = vld_q[LAT];
	assign out_flags = fl_q[LAT];
	assign out_x     = fl_q[LAT].par ? '0 : dx;
	assign out_y     = fl_q[LAT].par ? '0 : dy;

endmodule

>>> hdl/segment_intersect_point.sv
`timescale 1ns / 1ps
// path: front pipeline, then the item queue, then the back pipeline
// throughput: one item per cycle while neither part holds; the divider steps one quotient bit per stage
// the front holds when its last stage is loaded and the 4-entry queue is full
// the back holds when the result register is loaded and stalled
// reset: asynchronous, active low, clears all valid bits, pointers and counts
module segment_intersect_point import sid_pkg::*; #(
	parameter int COORD_BITS = 13
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic signed [COORD_BITS-1:0] first_start_x,
	input  logic signed [COORD_BITS-1:0] first_start_y,
	input  logic signed [COORD_BITS-1:0] first_end_x,
	input  logic signed [COORD_BITS-1:0] first_end_y,
	input  logic signed [COORD_BITS-1:0] second_start_x,
	input  logic signed [COORD_BITS-1:0] second_start_y,
	input  logic signed [COORD_BITS-1:0] second_end_x,
	input  logic signed [COORD_BITS-1:0] second_end_y,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic                         crosses,
	output logic                         parallel,
	output logic signed [COORD_BITS-1:0] cross_x,
	output logic signed [COORD_BITS-1:0] cross_y
);

	localparam int CB = COORD_BITS;
	localparam int DW = 2 * CB + 3;
	localparam int NW = 3 * CB + 3;
	localparam int QW = 2 + DW + 2 * NW;

	logic                 f_en, f_vld;
	sid_flags_t           f_flags;
	logic signed [DW-1:0] f_det;
	logic signed [NW-1:0] f_nx, f_ny;
	logic                 q_push, q_full, q_pop, q_empty;
	logic [QW-1:0]        q_din, q_dout;
	sid_flags_t           b_flags;
	sid_flags_t           o_flags;

	// front stalls only when its last stage cannot drain
	assign f_en       = !(f_vld && q_full);
	assign item_stall = !f_en;
	assign q_push     = f_vld && !q_full;

	sid_front #(.CB(CB)) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (f_en),
		.in_vld  (item_valid),
		.ax0     (first_start_x),
		.ay0     (first_start_y),
		.ax1     (first_end_x),
		.ay1     (first_end_y),
		.bx0     (second_start_x),
		.by0     (second_start_y),
		.bx1     (second_end_x),
		.by1     (second_end_y),
		.out_vld (f_vld),
		.flags   (f_flags),
		.det     (f_det),
		.numx    (f_nx),
		.numy    (f_ny)
	);

	assign q_din = {f_flags, f_det, f_nx, f_ny};

	sid_queue #(.W(QW)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.dout   (q_dout)
	);

	assign b_flags = q_dout[QW-1 -: 2];

	sid_back #(.CB(CB)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_pop     (q_pop),
		.q_flags   (b_flags),
		.q_det     (q_dout[QW-3 -: DW]),
		.q_numx    (q_dout[2*NW-1 -: NW]),
		.q_numy    (q_dout[NW-1:0]),
		.out_vld   (result_valid),
		.out_stall (result_stall),
		.out_flags (o_flags),
		.out_x     (cross_x),
		.out_y     (cross_y)
	);

	assign crosses  = o_flags.hit;
	assign parallel = o_flags.par;

`ifndef SYNTH
	// a parallel result carries a zero point
	a_par_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && parallel |-> cross_x == '0 && cross_y == '0)
		else $error("parallel result with nonzero point");

	// the queue is never pushed when full nor popped when empty
	a_queue_safe: assert property (@(posedge clk) disable iff (!arst_n)
		!(q_push && q_full) && !(q_pop && q_empty))
		else $error("queue overrun or underrun");

	// input stall only arises from a loaded front end facing a full queue
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> f_vld && q_full)
		else $error("input stalled without backpressure");
`endif

endmodule
